[sv/bls_pkg.sv]
package bls_pkg;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;
    localparam logic [1:0] CMD_DUMP = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] push_word;
    } bls_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] word;
        logic               last;
    } bls_out_t;

    typedef struct packed {
        logic       push_wr;
        logic       pop_dec;
        logic       rd_top;
        logic       rd_next;
        logic       load_direct;
        logic       load_mem;
        logic [1:0] load_status;
        logic       load_last;
    } bls_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic ptr_zero;
        logic out_free;
    } bls_stat_t;

endpackage

[sv/bounded_lifo_stack_core.sv]
// channel   ports                      payload
// input     s_valid s_ready s_data     bls_in_t  (cmd, push_word)
// result    m_valid m_ready m_data     bls_out_t (status, word, last)
//
// push and every overflow or empty result: item taken, result loaded straight into the output register
// pop and peek: stack memory read into a read register, then loaded into the output register
// dump of n entries: one memory read per entry, input held off
// aresetn (synchronous, active low) empties the stack; entries need no clear
// a stalled result holds the stack memory walk until m_ready
module bounded_lifo_stack_core #(
    parameter int DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bls_pkg::bls_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bls_pkg::bls_out_t m_data
);

    bls_pkg::bls_cmd_t  ctl;
    bls_pkg::bls_stat_t stat;

    bls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_cmd  (s_data.cmd),
        .stat    (stat),
        .ctl     (ctl)
    );

    bls_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .in_data (s_data),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[sv/bls_ctrl.sv]
module bls_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        in_cmd,
    input  bls_pkg::bls_stat_t stat,
    output bls_pkg::bls_cmd_t  ctl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic state_reg, state_next;
    logic dump_reg, dump_next;
    logic accept;

    assign s_ready = (state_reg == S_IDLE) && stat.out_free;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next      = state_reg;
        dump_next       = dump_reg;
        ctl             = '0;
        ctl.load_status = bls_pkg::STATUS_OK;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        bls_pkg::CMD_PUSH: begin
                            ctl.load_direct = 1'b1;
                            ctl.load_last   = 1'b1;
                            if (stat.full) begin
                                ctl.load_status = bls_pkg::STATUS_OVERFLOW;
                            end else begin
                                ctl.push_wr = 1'b1;
                            end
                        end
                        default: begin
                            if (stat.empty) begin
                                ctl.load_direct = 1'b1;
                                ctl.load_last   = 1'b1;
                                ctl.load_status = bls_pkg::STATUS_EMPTY;
                            end else begin
                                ctl.rd_top  = 1'b1;
                                ctl.pop_dec = (in_cmd == bls_pkg::CMD_POP);
                                dump_next   = (in_cmd == bls_pkg::CMD_DUMP);
                                state_next  = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                if (stat.out_free) begin
                    ctl.load_mem  = 1'b1;
                    ctl.load_last = !dump_reg || stat.ptr_zero;
                    if (dump_reg && !stat.ptr_zero) begin
                        ctl.rd_next = 1'b1;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            dump_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            dump_reg  <= dump_next;
        end
    end

endmodule

[sv/bls_datapath.sv]
module bls_datapath #(
    parameter int DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bls_pkg::bls_cmd_t  ctl,
    input  bls_pkg::bls_in_t   in_data,
    output bls_pkg::bls_stat_t stat,
    output logic               m_valid,
    input  logic               m_ready,
    output bls_pkg::bls_out_t  m_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [31:0]   mem [DEPTH];
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] fill_m1;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data_reg;
    logic          valid_reg, valid_next;
    bls_pkg::bls_out_t out_reg;

    assign fill_m1 = fill_reg - 1'b1;
    assign rd_addr = ctl.rd_top ? fill_m1[AW-1:0] : ptr_reg - 1'b1;

    assign stat.empty    = (fill_reg == '0);
    assign stat.full     = (fill_reg == FULL_COUNT);
    assign stat.ptr_zero = (ptr_reg == '0);
    assign stat.out_free = !valid_reg || m_ready;

    always_comb begin
        fill_next = fill_reg;
        if (ctl.push_wr) begin
            fill_next = fill_reg + 1'b1;
        end else if (ctl.pop_dec) begin
            fill_next = fill_m1;
        end
        ptr_next = ptr_reg;
        if (ctl.rd_top || ctl.rd_next) begin
            ptr_next = rd_addr;
        end
        valid_next = valid_reg && !m_ready;
        if (ctl.load_direct || ctl.load_mem) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push_wr) begin
            mem[fill_reg[AW-1:0]] <= in_data.push_word;
        end
        if (ctl.rd_top || ctl.rd_next) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_direct) begin
            out_reg.status <= ctl.load_status;
            out_reg.last   <= ctl.load_last;
            out_reg.word   <= (ctl.load_status == bls_pkg::STATUS_OK) ?
                              in_data.push_word : 32'sd0;
        end else if (ctl.load_mem) begin
            out_reg.status <= bls_pkg::STATUS_OK;
            out_reg.last   <= ctl.load_last;
            out_reg.word   <= rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            ptr_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            fill_reg  <= fill_next;
            ptr_reg   <= ptr_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = out_reg;

endmodule

[tb/sv/bounded_lifo_stack_core_tb.sv]
`timescale 1ns / 1ps

module bounded_lifo_stack_core_tb;

    localparam int STACK_DEPTH  = 16;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 230;
    localparam int HOLD_AT_ITEM = 60;

    class lifo_tracker;
        logic signed [31:0] words [STACK_DEPTH];
        int unsigned        used;
        int unsigned        errors;
        bls_pkg::bls_out_t  owed [$];

        function void owe(logic [1:0] status, logic signed [31:0] word, logic last);
            bls_pkg::bls_out_t r;
            r.status = status;
            r.word   = word;
            r.last   = last;
            owed.push_back(r);
        endfunction

        function void log_item(bls_pkg::bls_in_t item);
            int unsigned i;
            case (item.cmd)
                bls_pkg::CMD_PUSH: begin
                    if (used == STACK_DEPTH) begin
                        owe(bls_pkg::STATUS_OVERFLOW, '0, 1'b1);
                    end else begin
                        words[used] = item.push_word;
                        used++;
                        owe(bls_pkg::STATUS_OK, item.push_word, 1'b1);
                    end
                end
                bls_pkg::CMD_POP: begin
                    if (used == 0) begin
                        owe(bls_pkg::STATUS_EMPTY, '0, 1'b1);
                    end else begin
                        used--;
                        owe(bls_pkg::STATUS_OK, words[used], 1'b1);
                    end
                end
                bls_pkg::CMD_PEEK: begin
                    if (used == 0) begin
                        owe(bls_pkg::STATUS_EMPTY, '0, 1'b1);
                    end else begin
                        owe(bls_pkg::STATUS_OK, words[used - 1], 1'b1);
                    end
                end
                default: begin
                    if (used == 0) begin
                        owe(bls_pkg::STATUS_EMPTY, '0, 1'b1);
                    end else begin
                        for (i = used; i > 0; i--) begin
                            owe(bls_pkg::STATUS_OK, words[i - 1], i == 1);
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(bls_pkg::bls_out_t got);
            bls_pkg::bls_out_t want;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, %s %0d word %0d last %0b",
                         $time, "actual status", got.status, got.word, got.last);
            end else begin
                want = owed.pop_front();
                if (got.status !== want.status) begin
                    errors++;
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, got.status);
                end
                if (got.word !== want.word) begin
                    errors++;
                    $display("%0t: word mismatch, expected %0d actual %0d",
                             $time, want.word, got.word);
                end
                if (got.last !== want.last) begin
                    errors++;
                    $display("%0t: last mismatch, expected %0b actual %0b",
                             $time, want.last, got.last);
                end
            end
        endfunction
    endclass

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    bls_pkg::bls_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    bls_pkg::bls_out_t m_data;
    bit                hold_req = 1'b0;
    int unsigned       cycles   = 0;
    lifo_tracker       sb = new();

    bounded_lifo_stack_core #(.DEPTH(STACK_DEPTH)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
    end

    function automatic int unsigned pick_gap(bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic signed [31:0] random_word();
        case ($urandom_range(0, 9))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            3: return 32'shffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic bls_pkg::bls_in_t make_item(logic [1:0] cmd, logic signed [31:0] w);
        bls_pkg::bls_in_t item;
        item.cmd       = cmd;
        item.push_word = w;
        return item;
    endfunction

    task automatic send_item(input bls_pkg::bls_in_t item);
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = item;
        do @(posedge aclk); while (!s_ready);
        sb.log_item(item);
    endtask

    task automatic sender_idle(input int unsigned n);
        if (n > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    task automatic send_then_idle(input bls_pkg::bls_in_t item, input bit quiet);
        send_item(item);
        sender_idle(pick_gap(quiet));
    endtask

    // result side: random ready pattern, one long hold-off on request
    initial begin
        int unsigned r;
        int unsigned len;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready  = 1'b0;
                len      = LONG_HOLD;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    m_ready = 1'b1;
                    len     = $urandom_range(30, 80);
                end else if (r < 65) begin
                    m_ready = 1'b1;
                    len     = $urandom_range(1, 6);
                end else if (r < 93) begin
                    m_ready = 1'b0;
                    len     = $urandom_range(1, 3);
                end else begin
                    m_ready = 1'b0;
                    len     = $urandom_range(10, 40);
                end
            end
            repeat (len) @(negedge aclk);
        end
    end

    initial begin
        logic signed [31:0] edge_words [7];
        logic [1:0]         cmd;
        int unsigned        push_bias;
        int unsigned        r;
        bit                 quiet;
        int                 k;

        edge_words[0] = 32'sh7fff_ffff;
        edge_words[1] = 32'sh8000_0000;
        edge_words[2] = 32'sh0000_0000;
        edge_words[3] = 32'shffff_ffff;
        edge_words[4] = 32'sh5555_5555;
        edge_words[5] = 32'shaaaa_aaaa;
        edge_words[6] = 32'sh0000_0001;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty stack cases
        send_then_idle(make_item(bls_pkg::CMD_POP, random_word()), 1'b0);
        send_then_idle(make_item(bls_pkg::CMD_PEEK, random_word()), 1'b0);
        send_then_idle(make_item(bls_pkg::CMD_DUMP, random_word()), 1'b0);
        // fill to the top, overflow, then peek, dump and pop the full stack
        for (k = 0; k < STACK_DEPTH; k++) begin
            send_then_idle(make_item(bls_pkg::CMD_PUSH,
                                     (k < 7) ? edge_words[k] : random_word()), 1'b0);
        end
        send_then_idle(make_item(bls_pkg::CMD_PUSH, random_word()), 1'b0);
        send_then_idle(make_item(bls_pkg::CMD_PEEK, random_word()), 1'b0);
        send_then_idle(make_item(bls_pkg::CMD_DUMP, random_word()), 1'b0);
        send_then_idle(make_item(bls_pkg::CMD_POP, random_word()), 1'b0);

        push_bias = 50;
        quiet     = 1'b0;
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 20 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_bias = 20;
                    1: push_bias = 50;
                    default: push_bias = 85;
                endcase
                quiet = ($urandom_range(0, 4) == 0);
            end
            if (k == HOLD_AT_ITEM) begin
                hold_req  = 1'b1;
                push_bias = 85;
                quiet     = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 6) begin
                cmd = bls_pkg::CMD_DUMP;
            end else if (r < 14) begin
                cmd = bls_pkg::CMD_PEEK;
            end else if (r < 14 + (86 * push_bias) / 100) begin
                cmd = bls_pkg::CMD_PUSH;
            end else begin
                cmd = bls_pkg::CMD_POP;
            end
            send_then_idle(make_item(cmd, random_word()), quiet);
        end
        sender_idle(1);

        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
